// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/b128ge_pkg.sv =====
package b128ge_pkg;

   localparam int GROUP_BYTES       = 7;
   localparam int SYMBOLS_PER_GROUP = 8;
   localparam int SYM_BITS          = 7;
   localparam int WORD_BITS         = GROUP_BYTES * 8;
   localparam int CNT_BITS          = 3;
   localparam int IDX_BITS          = $clog2(SYMBOLS_PER_GROUP);
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // one finished group handed from front to back
   typedef struct packed {
      logic [WORD_BITS-1:0] bits;
      logic [CNT_BITS-1:0]  n_bytes;   // data bytes held, 7 for a full group
      logic                 msg_last;
   } grp_type;

   // queue handshake seen by the front
   typedef struct packed {
      logic push;
      logic full;
   } qwr_type;

   // queue handshake seen by the back
   typedef struct packed {
      logic valid;
      logic pop;
   } qrd_type;

   function automatic logic [7:0] symbol_of(input logic [SYM_BITS-1:0] v);
      logic [7:0] w;
      logic [7:0] s;
      w = {1'b0, v};
      case (v) inside
         [7'd0:7'd9]:     s = 8'(8'h30 + w);
         [7'd10:7'd35]:   s = 8'(8'h41 + w - 8'd10);
         [7'd36:7'd61]:   s = 8'(8'h61 + w - 8'd36);
         [7'd62:7'd84]:   s = 8'(8'hC0 + w - 8'd62);
         [7'd85:7'd115]:  s = 8'(8'hD8 + w - 8'd85);
         [7'd116:7'd123]: s = 8'(8'hF8 + w - 8'd116);
         7'd124:          s = 8'hB0;
         7'd125:          s = 8'hB9;
         7'd126:          s = 8'hB2;
         default:         s = 8'hB3;
      endcase
      return s;
   endfunction

endpackage

// ===== src/b128ge_front.sv =====
`include "assert_macros.svh"

module b128ge_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_message_last,
   output b128ge_pkg::qwr_type  qwr,
   input  logic                 q_full,
   output b128ge_pkg::grp_type  grp
);

   logic [b128ge_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0] bytes_ff [b128ge_pkg::GROUP_BYTES];
   logic       complete;
   logic       accept;

   // a byte that closes a group needs a free queue slot
   assign complete  = (cnt_ff == b128ge_pkg::CNT_BITS'(b128ge_pkg::GROUP_BYTES - 1))
                      || req_message_last;
   assign req_stall = complete && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      qwr.push = accept && complete;
      qwr.full = q_full;
      if (qwr.push) begin
         cnt_in = '0;
      end else if (accept) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // stale bytes above the count read as zero padding
   always_comb begin
      for (int i = 0; i < b128ge_pkg::GROUP_BYTES; i++) begin
         if (b128ge_pkg::CNT_BITS'(i) < cnt_ff) begin
            grp.bits[8*i +: 8] = bytes_ff[i];
         end else if (b128ge_pkg::CNT_BITS'(i) == cnt_ff) begin
            grp.bits[8*i +: 8] = req_in_byte;
         end else begin
            grp.bits[8*i +: 8] = 8'h00;
         end
      end
      grp.n_bytes  = cnt_ff + 1'b1;
      grp.msg_last = req_message_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff[cnt_ff] <= req_in_byte;
      end
   end

   `ASSERT_NEVER(a_cnt_range, clock, reset,
      cnt_ff >= b128ge_pkg::CNT_BITS'(b128ge_pkg::GROUP_BYTES), "byte count out of range")
   `ASSERT_ALWAYS(a_push_room, clock, reset, qwr.push |-> !q_full, "push into full queue")

endmodule

// ===== src/b128ge_queue.sv =====
`include "assert_macros.svh"

module b128ge_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  b128ge_pkg::qwr_type  qwr,
   input  b128ge_pkg::grp_type  wr_grp,
   output logic                 full,
   input  b128ge_pkg::qrd_type  qrd,
   output logic                 valid,
   output b128ge_pkg::grp_type  rd_grp
);

   localparam int PTR_BITS = $clog2(b128ge_pkg::QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(b128ge_pkg::QUEUE_DEPTH + 1);

   b128ge_pkg::grp_type       slot_ff [b128ge_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = (count_ff == CNT_W'(b128ge_pkg::QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign rd_grp  = slot_ff[rd_ptr_ff];
   assign do_push = qwr.push && !full;
   assign do_pop  = qrd.pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(b128ge_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(b128ge_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_grp;
      end
   end

   `ASSERT_NEVER(a_q_over, clock, reset,
      count_ff > CNT_W'(b128ge_pkg::QUEUE_DEPTH), "queue count over depth")
   `ASSERT_ALWAYS(a_q_pop, clock, reset, qrd.pop |-> valid, "pop from empty queue")

endmodule

// ===== src/b128ge_back.sv =====
`include "assert_macros.svh"

module b128ge_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  b128ge_pkg::grp_type  q_grp,
   output b128ge_pkg::qrd_type  qrd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_group_last,
   output logic                 rsp_message_end
);

   logic                                busy_ff, busy_in;
   logic [b128ge_pkg::IDX_BITS-1:0]     idx_ff, idx_in;
   b128ge_pkg::grp_type                 grp_ff;
   logic                                out_valid_ff, out_valid_in;
   logic [7:0]                          char_ff;
   logic                                glast_ff, mend_ff;
   logic                                load_out, advance, last_sym, pop;
   logic [b128ge_pkg::SYM_BITS-1:0]     chunk;
   logic                                is_pad;

   assign load_out = !out_valid_ff || !rsp_stall;
   assign advance  = busy_ff && load_out;
   assign last_sym = (idx_ff == b128ge_pkg::IDX_BITS'(b128ge_pkg::SYMBOLS_PER_GROUP - 1));
   assign pop      = q_valid && (!busy_ff || (advance && last_sym));
   assign chunk    = grp_ff.bits[b128ge_pkg::SYM_BITS*idx_ff +: b128ge_pkg::SYM_BITS];
   assign is_pad   = idx_ff > grp_ff.n_bytes;

   always_comb begin
      qrd.valid = q_valid;
      qrd.pop   = pop;
      if (pop) begin
         busy_in = 1'b1;
      end else if (advance && last_sym) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
      if (pop) begin
         idx_in = '0;
      end else if (advance) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
      out_valid_in = load_out ? busy_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         grp_ff <= q_grp;
      end
      if (advance) begin
         char_ff  <= is_pad ? b128ge_pkg::PAD_CHAR : b128ge_pkg::symbol_of(chunk);
         glast_ff <= last_sym;
         mend_ff  <= last_sym && grp_ff.msg_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_group_last  = glast_ff;
   assign rsp_message_end = mend_ff;

   `ASSERT_ALWAYS(a_end_on_last, clock, reset,
      (rsp_valid && rsp_message_end) |-> rsp_group_last, "message end off group end")
   `ASSERT_ALWAYS(a_pop_idle, clock, reset,
      (pop && busy_ff) |-> last_sym, "group reloaded mid group")

endmodule

// ===== src/base128_group_encoder_core.sv =====
// a group's closing byte goes into a queue slot, then the back's group register, and its
// first symbol into the output register; one byte per cycle in while req_stall is low,
//   the single-symbol back end gives one symbol per cycle unless rsp_stall, 8 per group
// a 2-entry group queue lets the front take bytes while the back is still emitting
// reset: synchronous, active high; clears byte count, queue and output valid
module base128_group_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_message_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_group_last,
   output logic       rsp_message_end
);

   // front to queue
   b128ge_pkg::qwr_type qwr;
   b128ge_pkg::grp_type wr_grp;
   logic                q_full;

   // queue to back
   b128ge_pkg::qrd_type qrd;
   b128ge_pkg::grp_type rd_grp;
   logic                q_valid;

   // front: collects bytes, closes a group on the seventh byte or on message end
   b128ge_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_message_last (req_message_last),
      .qwr              (qwr),
      .q_full           (q_full),
      .grp              (wr_grp)
   );

   // short queue of closed groups, decouples front and back stalls
   b128ge_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .qwr    (qwr),
      .wr_grp (wr_grp),
      .full   (q_full),
      .qrd    (qrd),
      .valid  (q_valid),
      .rd_grp (rd_grp)
   );

   // back: walks 8 symbols of a group through the alphabet, pads after data,
   // registered output so the result item waits without blocking the queue
   b128ge_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_grp           (rd_grp),
      .qrd             (qrd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_group_last  (rsp_group_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// ===== verif/tb_base128_group_encoder_core.sv =====
module tb_base128_group_encoder_core;

   // one input item as the sender presents it
   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   // one symbol as the encoder should deliver it
   typedef struct {
      logic [7:0] ch;
      logic       grp_end;
      logic       msg_end;
   } symbol_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_message_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_char;
   logic       rsp_group_last;
   logic       rsp_message_end;

   base128_group_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_message_last (req_message_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_group_last   (rsp_group_last),
      .rsp_message_end  (rsp_message_end)
   );

   byte_item_type  pending_bytes[$];
   symbol_type     expected_symbols[$];

   // encoder state mirrored on the testbench side
   logic [b128ge_pkg::WORD_BITS-1:0] group_word;
   int unsigned                      group_fill;

   int unsigned errors;
   int unsigned bytes_sent;
   int unsigned messages_queued;
   int unsigned symbols_checked;
   int unsigned groups_seen;
   int unsigned partial_groups;

   bit          tx_idle_on;
   bit          rx_idle_on;
   int unsigned tx_gap_left;
   int unsigned rx_hold_left;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // 7-bit value to its alphabet character
   function automatic logic [7:0] alphabet_char(input logic [b128ge_pkg::SYM_BITS-1:0] v);
      logic [7:0] w;
      w = 8'(v);
      if (w < 8'd10)       return 8'h30 + w;
      else if (w < 8'd36)  return 8'h41 + (w - 8'd10);
      else if (w < 8'd62)  return 8'h61 + (w - 8'd36);
      else if (w < 8'd85)  return 8'hC0 + (w - 8'd62);
      else if (w < 8'd116) return 8'hD8 + (w - 8'd85);
      else if (w < 8'd124) return 8'hF8 + (w - 8'd116);
      case (w)
         8'd124:  return 8'hB0;
         8'd125:  return 8'hB9;
         8'd126:  return 8'hB2;
         default: return 8'hB3;
      endcase
   endfunction

   // mostly short idles, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // packs one accepted byte, queues the group's symbols once it closes
   task automatic encode_byte(input logic [7:0] b, input logic last);
      symbol_type  s;
      int unsigned n_data;
      group_word[8*group_fill +: 8] = b;
      group_fill++;
      if (group_fill < b128ge_pkg::GROUP_BYTES && !last) return;
      n_data = (group_fill == b128ge_pkg::GROUP_BYTES) ? b128ge_pkg::SYMBOLS_PER_GROUP
                                                       : group_fill + 1;
      if (group_fill < b128ge_pkg::GROUP_BYTES) partial_groups++;
      for (int k = 0; k < b128ge_pkg::SYMBOLS_PER_GROUP; k++) begin
         s.ch      = (k < n_data)
                     ? alphabet_char(group_word[b128ge_pkg::SYM_BITS*k +: b128ge_pkg::SYM_BITS])
                     : b128ge_pkg::PAD_CHAR;
         s.grp_end = (k == b128ge_pkg::SYMBOLS_PER_GROUP - 1);
         s.msg_end = (k == b128ge_pkg::SYMBOLS_PER_GROUP - 1) && last;
         expected_symbols.push_back(s);
      end
      group_word = '0;
      group_fill = 0;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last);
      byte_item_type it;
      it.data = data;
      it.last = last;
      pending_bytes.push_back(it);
      if (last) messages_queued++;
   endtask

   // random messages, lengths biased toward partial and full group boundaries
   task automatic queue_random_messages(input int unsigned n_items);
      int unsigned added;
      int unsigned len;
      int unsigned r;
      logic [7:0]  b;
      added = 0;
      while (added < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 55)      len = $urandom_range(1, 7);
         else if (r < 85) len = $urandom_range(8, 21);
         else             len = 7 * $urandom_range(1, 3);
         for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      b = 8'h00;
            else if (r == 1) b = 8'hFF;
            else             b = 8'($urandom_range(0, 255));
            push_byte(b, i == len - 1);
         end
         added += len;
      end
   endtask

   // holds the sender until every queued symbol has come back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_symbols.size() != 0)
         @(negedge clock);
   endtask

   // driver: presents queued bytes, predicts on each acceptance
   always @(posedge clock) begin
      byte_item_type nxt;
      if (reset) begin
         req_valid   <= 1'b0;
         tx_gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            encode_byte(req_in_byte, req_message_last);
            bytes_sent++;
            if (tx_idle_on) tx_gap_left = pick_gap();
         end
         if (tx_gap_left != 0) begin
            tx_gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            nxt = pending_bytes.pop_front();
            req_valid        <= 1'b1;
            req_in_byte      <= nxt.data;
            req_message_last <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks each accepted symbol, then picks the next stall
   always @(posedge clock) begin
      symbol_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            errors++;
            $display("%0t: unexpected symbol char=%02h group_last=%b message_end=%b",
                     $time, rsp_out_char, rsp_group_last, rsp_message_end);
         end else begin
            want = expected_symbols.pop_front();
            symbols_checked++;
            if (rsp_group_last) groups_seen++;
            if (rsp_out_char !== want.ch) begin
               errors++;
               $display("%0t: out_char expected %02h actual %02h",
                        $time, want.ch, rsp_out_char);
            end
            if (rsp_group_last !== want.grp_end) begin
               errors++;
               $display("%0t: group_last expected %b actual %b",
                        $time, want.grp_end, rsp_group_last);
            end
            if (rsp_message_end !== want.msg_end) begin
               errors++;
               $display("%0t: message_end expected %b actual %b",
                        $time, want.msg_end, rsp_message_end);
            end
         end
      end
      if (rx_hold_left != 0) begin
         rx_hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
         rx_hold_left = pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = 8'h00;
      req_message_last = 1'b0;
      rsp_stall        = 1'b0;
      group_word       = '0;
      group_fill       = 0;
      errors           = 0;
      bytes_sent       = 0;
      messages_queued  = 0;
      symbols_checked  = 0;
      groups_seen      = 0;
      partial_groups   = 0;
      tx_idle_on       = 1'b0;
      rx_idle_on       = 1'b0;
      tx_gap_left      = 0;
      rx_hold_left     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: one-byte messages at both byte extremes
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      // partial groups of three and six bytes
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b1);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h0F, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h3C, 1'b1);
      // full group of ones closing the message
      for (int i = 0; i < b128ge_pkg::GROUP_BYTES; i++)
         push_byte(8'hFF, i == b128ge_pkg::GROUP_BYTES - 1);
      // full group of zeros in the middle of a message
      for (int i = 0; i < b128ge_pkg::GROUP_BYTES; i++) push_byte(8'h00, 1'b0);
      wait_drained();

      // random traffic with idles on both sides
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      queue_random_messages(28);
      // sender pause until all symbols are back
      wait_drained();

      // sender at full rate against a stalling receiver
      tx_idle_on = 1'b0;
      queue_random_messages(24);
      wait_drained();

      // idles on both sides again
      tx_idle_on = 1'b1;
      queue_random_messages(24);
      wait_drained();

      rx_idle_on = 1'b0;
      repeat (20) @(negedge clock);

      $display("run covered %0d bytes in %0d messages, %0d groups (%0d partial)",
               bytes_sent, messages_queued, groups_seen, partial_groups);
      $display("%0d symbols checked, %0d mismatches", symbols_checked, errors);
      if (errors == 0) begin
         $display("PASS base128_group_encoder_core");
      end else begin
         $display("FAIL base128_group_encoder_core");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(20 * 400000);
      $display("FAIL base128_group_encoder_core");
      $finish;
   end

endmodule
